// File: rtl/tkcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkcs_pkg: shared types and constants for the top-k per column select
// Value width, configuration register map, cell control struct and the
// score function that ranks a stored or incoming value.
// ----------------------------------------------------------------------------
package tkcs_pkg;

  localparam int VALUE_W   = 32;
  localparam int SCORE_W   = VALUE_W + 1;
  localparam int KEEP_W    = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = KEEP_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEEP_COUNT     = 1'b0,
    REG_MAGNITUDE_MODE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic insert;     // cell takes part in this insertion
    logic from_prev;  // take the neighbor's entry instead of the new one
    logic pop;        // drain: take the entry of the next cell
  } cell_ctrl_t;

  // Signed value, or its magnitude; one extra bit keeps 2^31 exact.
  function automatic logic signed [SCORE_W-1:0] score_of(
    input logic signed [VALUE_W-1:0] value,
    input logic                      magnitude
  );
    logic signed [SCORE_W-1:0] ext;
    ext = {value[VALUE_W-1], value};
    return (magnitude && value[VALUE_W-1]) ? -ext : ext;
  endfunction

endpackage

// File: rtl/tkcs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkcs_if: valid/ready channels of the top-k per column select
// One interface for column entries, one for ranked results.
// ----------------------------------------------------------------------------
interface tkcs_in_if #(parameter int ROW_BITS = 20);
  logic                       valid;
  logic                       ready;
  logic signed [31:0]         sample_value;
  logic [ROW_BITS-1:0]        row_number;
  logic                       value_absent;
  logic                       column_end;

  modport source (output valid, sample_value, row_number, value_absent, column_end,
                  input ready);
  modport sink   (input valid, sample_value, row_number, value_absent, column_end,
                  output ready);
endinterface

interface tkcs_out_if #(parameter int ROW_BITS = 20);
  logic                       valid;
  logic                       ready;
  logic [ROW_BITS:0]          ranked_row;
  logic signed [31:0]         ranked_value;
  logic                       is_padding;
  logic                       last_of_column;

  modport source (output valid, ranked_row, ranked_value, is_padding, last_of_column,
                  input ready);
  modport sink   (input valid, ranked_row, ranked_value, is_padding, last_of_column,
                  output ready);
endinterface

// File: rtl/tkcs_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkcs_cell: one rank slot of the insertion chain
// Holds one kept entry, compares its score against the incoming score and
// takes the new entry, its upstream neighbor's entry, or its downstream
// neighbor's entry while the column drains.
// ----------------------------------------------------------------------------
module tkcs_cell
  import tkcs_pkg::*;
#(
  parameter int ROW_BITS = 20
) (
  input  logic                        clk,
  input  cell_ctrl_t                  ctrl,
  input  logic                        occupied,
  input  logic                        magnitude_mode,
  input  logic signed [SCORE_W-1:0]   new_score,
  input  logic signed [VALUE_W-1:0]   new_value,
  input  logic [ROW_BITS-1:0]         new_row,
  input  logic signed [VALUE_W-1:0]   prev_value,
  input  logic [ROW_BITS-1:0]         prev_row,
  input  logic signed [VALUE_W-1:0]   next_value,
  input  logic [ROW_BITS-1:0]         next_row,
  output logic                        beaten,
  output logic signed [VALUE_W-1:0]   value,
  output logic [ROW_BITS-1:0]         row
);

  // strict compare: an equal score stays ahead of the newcomer
  assign beaten = !occupied || (new_score > score_of(value, magnitude_mode));

  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      value <= next_value;
      row   <= next_row;
    end else if (ctrl.insert) begin
      if (ctrl.from_prev) begin
        value <= prev_value;
        row   <= prev_row;
      end else begin
        value <= new_value;
        row   <= new_row;
      end
    end
  end

endmodule

// File: rtl/top_k_per_column_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_per_column_select: streaming top-k selection per column
// A chain of MAX_KEEP cells keeps the strongest entries in rank order; a
// column end drains the first k cells through an output register.
// ----------------------------------------------------------------------------
// Sequence: an entry is absorbed in the cycle it is accepted; a column-end
//   beat sets the drain flag, and results then leave through the output register.
// Throughput: one entry per cycle within a column; a column end then holds the
//   input while the chain shifts out k results, one a cycle unless rank_out stalls.
// Reset: clears the fill count, drain control and output valid; k = 1 and
//   signed ranking. Cell contents are not cleared (read only below fill).
module top_k_per_column_select
  import tkcs_pkg::*;
#(
  parameter int MAX_KEEP = 16,
  parameter int ROW_BITS = 20
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    write_enable,
  input  logic [CFG_IDX_W-1:0]    reg_index,
  input  logic [CFG_DATA_W-1:0]   write_data,
  tkcs_in_if.sink                 sample_in,
  tkcs_out_if.source              rank_out
);

  localparam int CNT_W = $clog2(MAX_KEEP + 1);

  logic [KEEP_W-1:0]            keep_count;
  logic                         magnitude_mode;
  logic [CNT_W-1:0]             fill;
  logic [CNT_W-1:0]             fill_next;
  logic [CNT_W-1:0]             fill_clip;
  logic [CNT_W-1:0]             k_eff;
  logic [CNT_W-1:0]             emit_cnt;
  logic                         draining;
  logic                         in_acc;
  logic                         pop;
  logic                         emit_last;
  logic                         ins_any;
  logic                         admit;
  logic                         weakest_beaten;
  logic signed [SCORE_W-1:0]    new_score;

  logic [MAX_KEEP-1:0]          beaten;
  logic [MAX_KEEP-1:0]          past_pos;
  logic [MAX_KEEP-1:0]          insert;
  logic signed [VALUE_W-1:0]    cell_value [MAX_KEEP];
  logic [ROW_BITS-1:0]          cell_row   [MAX_KEEP];

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count     <= KEEP_W'(1);
      magnitude_mode <= 1'b0;
    end else if (write_enable) begin
      unique case (cfg_reg_t'(reg_index))
        REG_KEEP_COUNT:     keep_count     <= write_data;
        REG_MAGNITUDE_MODE: magnitude_mode <= write_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (keep_count == '0) begin
      k_eff = CNT_W'(1);
    end else if (int'(keep_count) > MAX_KEEP) begin
      k_eff = CNT_W'(MAX_KEEP);
    end else begin
      k_eff = CNT_W'(keep_count);
    end
  end

  // drop entries beyond a lowered k
  assign fill_clip = (fill > k_eff) ? k_eff : fill;

  assign sample_in.ready = !draining;
  assign in_acc    = sample_in.valid && sample_in.ready;
  assign new_score = score_of(sample_in.sample_value, magnitude_mode);

  assign pop       = draining && (!rank_out.valid || rank_out.ready);
  assign emit_last = (emit_cnt == k_eff - CNT_W'(1));

  // the first beaten slot takes the new entry, every slot after it shifts down
  always_comb begin
    past_pos[0]    = beaten[0];
    weakest_beaten = (k_eff == CNT_W'(1)) && beaten[0];
    for (int i = 1; i < MAX_KEEP; i++) begin
      past_pos[i] = past_pos[i-1] || beaten[i];
      if (CNT_W'(i + 1) == k_eff) begin
        weakest_beaten = beaten[i];
      end
    end
  end

  // a full store admits only a score above the weakest kept one
  assign admit = in_acc && !sample_in.value_absent
                 && ((fill_clip != k_eff) || weakest_beaten);

  // cell chain
  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    cell_ctrl_t                 ctrl;
    logic signed [VALUE_W-1:0]  prev_value;
    logic [ROW_BITS-1:0]        prev_row;
    logic signed [VALUE_W-1:0]  next_value;
    logic [ROW_BITS-1:0]        next_row;

    assign insert[i] = admit && past_pos[i] && (CNT_W'(i) < k_eff);

    if (i == 0) begin : g_head
      assign prev_value     = sample_in.sample_value;
      assign prev_row       = sample_in.row_number;
      assign ctrl.from_prev = 1'b0;
    end else begin : g_body
      assign prev_value     = cell_value[i-1];
      assign prev_row       = cell_row[i-1];
      assign ctrl.from_prev = past_pos[i-1];
    end

    if (i == MAX_KEEP - 1) begin : g_tail
      assign next_value = cell_value[i];
      assign next_row   = cell_row[i];
    end else begin : g_inner
      assign next_value = cell_value[i+1];
      assign next_row   = cell_row[i+1];
    end

    assign ctrl.insert = insert[i];
    assign ctrl.pop    = pop;

    tkcs_cell #(
      .ROW_BITS (ROW_BITS)
    ) u_cell (
      .clk            (clk),
      .ctrl           (ctrl),
      .occupied       (fill_clip > CNT_W'(i)),
      .magnitude_mode (magnitude_mode),
      .new_score      (new_score),
      .new_value      (sample_in.sample_value),
      .new_row        (sample_in.row_number),
      .prev_value     (prev_value),
      .prev_row       (prev_row),
      .next_value     (next_value),
      .next_row       (next_row),
      .beaten         (beaten[i]),
      .value          (cell_value[i]),
      .row            (cell_row[i])
    );
  end

  assign ins_any = |insert;

  always_comb begin
    fill_next = fill_clip;
    if (ins_any && (fill_clip != k_eff)) begin
      fill_next = fill_clip + CNT_W'(1);
    end
  end

  // fill count and drain control
  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      draining <= 1'b0;
      emit_cnt <= '0;
    end else if (pop) begin
      if (fill != '0) begin
        fill <= fill - CNT_W'(1);
      end
      if (emit_last) begin
        draining <= 1'b0;
        emit_cnt <= '0;
      end else begin
        emit_cnt <= emit_cnt + CNT_W'(1);
      end
    end else if (in_acc) begin
      fill     <= fill_next;
      draining <= sample_in.column_end;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rank_out.valid <= 1'b0;
    end else if (pop) begin
      rank_out.valid <= 1'b1;
    end else if (rank_out.ready) begin
      rank_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (fill != '0) begin
        rank_out.ranked_row   <= {1'b0, cell_row[0]} + (ROW_BITS + 1)'(1);
        rank_out.ranked_value <= cell_value[0];
        rank_out.is_padding   <= 1'b0;
      end else begin
        rank_out.ranked_row   <= '0;
        rank_out.ranked_value <= '0;
        rank_out.is_padding   <= 1'b1;
      end
      rank_out.last_of_column <= emit_last;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    int'(fill) <= MAX_KEEP)
    else $error("fill count above chain length");

  a_end_starts_drain: assert property (@(posedge clk) disable iff (rst)
    in_acc && sample_in.column_end |=> draining && emit_cnt == '0)
    else $error("column end did not start a drain");

  a_drain_empties: assert property (@(posedge clk) disable iff (rst)
    pop && emit_last |=> !draining && fill == '0)
    else $error("drain finished with entries left");

  a_padding_zero: assert property (@(posedge clk) disable iff (rst)
    rank_out.valid && rank_out.is_padding |->
      rank_out.ranked_row == '0 && rank_out.ranked_value == '0)
    else $error("padding beat carries data");

  a_last_ends_drain: assert property (@(posedge clk) disable iff (rst)
    pop |=> rank_out.last_of_column == !draining)
    else $error("last_of_column out of step with drain");
`endif

endmodule

// File: dv/top_k_per_column_select_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_per_column_select_tb: self-checking bench for the top-k column select
// Streams columns of Q16.16 entries under random source gaps and sink stalls.
// A scoreboard model ranks each column and checks every ranked beat in order.
// ----------------------------------------------------------------------------
module top_k_per_column_select_tb
  import tkcs_pkg::*;
();

  localparam int MAX_KEEP     = 16;
  localparam int ROW_BITS     = 20;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 150;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 10;

  localparam logic RANK_SIGNED    = 1'b0;
  localparam logic RANK_MAGNITUDE = 1'b1;

  typedef struct {
    logic [ROW_BITS:0] row;
    logic [31:0]       value;
    logic              pad;
    logic              last;
  } rank_beat_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  write_enable;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] write_data;

  tkcs_in_if  #(.ROW_BITS(ROW_BITS)) entry_ch ();
  tkcs_out_if #(.ROW_BITS(ROW_BITS)) rank_ch ();

  top_k_per_column_select #(
    .MAX_KEEP(MAX_KEEP),
    .ROW_BITS(ROW_BITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .sample_in    (entry_ch.sink),
    .rank_out     (rank_ch.source)
  );

  always #2 clk = ~clk;

  // Scoreboard copy of the ranking store and configuration
  logic [31:0]         kept_value [MAX_KEEP];
  logic [ROW_BITS-1:0] kept_row   [MAX_KEEP];
  int                  kept_fill = 0;
  logic [KEEP_W-1:0]   keep_cfg  = 5'd1;
  logic                mag_cfg   = RANK_SIGNED;

  rank_beat_t pending_ranks[$];
  int         errors         = 0;
  int         columns_closed = 0;
  int         beats_checked  = 0;

  bit   src_gaps    = 1'b1;
  logic sink_stalls = 1'b1;
  logic hold_req    = 1'b0;
  logic hold_ack    = 1'b0;

  function automatic longint rank_score(input logic [31:0] value);
    longint s;
    s = longint'($signed(value));
    if (mag_cfg == RANK_MAGNITUDE && s < 0) s = -s;
    return s;
  endfunction

  function automatic int active_keep();
    if (keep_cfg == 0) return 1;
    if (keep_cfg > MAX_KEEP) return MAX_KEEP;
    return int'(keep_cfg);
  endfunction

  function automatic void predict_entry(input logic [31:0] value,
                                        input logic [ROW_BITS-1:0] row,
                                        input logic absent, input logic last);
    int         k;
    int         pos;
    int         j;
    longint     s;
    rank_beat_t beat;
    k = active_keep();
    // a lowered k drops the weakest entries beyond it
    if (kept_fill > k) kept_fill = k;
    if (!absent) begin
      s = rank_score(value);
      // equal to the weakest kept score is not enough to evict it
      if (kept_fill < k || s > rank_score(kept_value[k-1])) begin
        if (kept_fill >= k) kept_fill = k - 1;
        pos = 0;
        while (pos < kept_fill && rank_score(kept_value[pos]) >= s) pos++;
        for (j = kept_fill; j > pos; j--) begin
          kept_value[j] = kept_value[j-1];
          kept_row[j]   = kept_row[j-1];
        end
        kept_value[pos] = value;
        kept_row[pos]   = row;
        kept_fill++;
      end
    end
    if (last) begin
      for (j = 0; j < k; j++) begin
        if (j < kept_fill) begin
          beat.row   = {1'b0, kept_row[j]} + 1'b1;
          beat.value = kept_value[j];
          beat.pad   = 1'b0;
        end else begin
          beat.row   = '0;
          beat.value = '0;
          beat.pad   = 1'b1;
        end
        beat.last = (j == k - 1);
        pending_ranks.insert(pending_ranks.size(), beat);
      end
      kept_fill = 0;
      columns_closed++;
    end
  endfunction

  // Predict on accepted entries, check each accepted ranked beat
  always @(posedge clk) begin
    rank_beat_t want;
    if (rst === 1'b0) begin
      if (entry_ch.valid === 1'b1 && entry_ch.ready === 1'b1)
        predict_entry(entry_ch.sample_value, entry_ch.row_number,
                      entry_ch.value_absent, entry_ch.column_end);
      if (rank_ch.valid === 1'b1 && rank_ch.ready === 1'b1) begin
        if (pending_ranks.size() == 0) begin
          $display("%0t unexpected ranked beat: row %0d value %h pad %b last %b", $time,
                   rank_ch.ranked_row, rank_ch.ranked_value, rank_ch.is_padding,
                   rank_ch.last_of_column);
          errors++;
        end else begin
          want = pending_ranks.pop_front();
          beats_checked++;
          if (rank_ch.ranked_row !== want.row) begin
            $display("%0t ranked_row mismatch: expected %0d, actual %0d", $time,
                     want.row, rank_ch.ranked_row);
            errors++;
          end
          if (rank_ch.ranked_value !== want.value) begin
            $display("%0t ranked_value mismatch: expected %h, actual %h", $time,
                     want.value, rank_ch.ranked_value);
            errors++;
          end
          if (rank_ch.is_padding !== want.pad) begin
            $display("%0t is_padding mismatch: expected %b, actual %b", $time,
                     want.pad, rank_ch.is_padding);
            errors++;
          end
          if (rank_ch.last_of_column !== want.last) begin
            $display("%0t last_of_column mismatch: expected %b, actual %b", $time,
                     want.last, rank_ch.last_of_column);
            errors++;
          end
        end
      end
    end
  end

  // Result sink: random stalls, plus a long hold-off on request
  initial begin : result_sink
    int left;
    left = 0;
    rank_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        left     = HOLD_CYCLES;
      end
      if (left != 0) begin
        left--;
        rank_ch.ready <= 1'b0;
      end else begin
        rank_ch.ready <= !(sink_stalls && $urandom_range(0, 99) < 25);
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d beats outstanding", CYCLE_LIMIT,
             pending_ranks.size());
    $display("status: fail");
    $finish;
  end

  task automatic write_reg(input cfg_reg_t index, input logic [CFG_DATA_W-1:0] data);
    write_enable <= 1'b1;
    reg_index    <= index;
    write_data   <= data;
    @(posedge clk);
    write_enable <= 1'b0;
    case (index)
      REG_KEEP_COUNT:     keep_cfg = data;
      REG_MAGNITUDE_MODE: mag_cfg  = data[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_entry(input logic [31:0] value, input logic [ROW_BITS-1:0] row,
                            input logic absent, input logic last);
    while (src_gaps && $urandom_range(0, 99) < 25) begin
      entry_ch.valid <= 1'b0;
      @(posedge clk);
    end
    entry_ch.valid        <= 1'b1;
    entry_ch.sample_value <= value;
    entry_ch.row_number   <= row;
    entry_ch.value_absent <= absent;
    entry_ch.column_end   <= last;
    @(posedge clk);
    while (entry_ch.ready !== 1'b1) @(posedge clk);
  endtask

  // Stop offering beats and wait until every ranked beat is back
  task automatic wait_drained();
    entry_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_ranks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_sample();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5, 6:    v = int'($urandom_range(0, 8)) - 4;  // small range forces ties
      7: begin
        case ($urandom_range(0, 4))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7FFF_FFFF;
          2:       v = 32'h0000_0000;
          3:       v = 32'hFFFF_FFFF;
          default: v = 32'h8000_0001;
        endcase
      end
      default:    v = int'($urandom_range(0, 32'h1_FFFF)) - 32'h1_0000;
    endcase
    return v;
  endfunction

  task automatic send_random_columns(input int budget);
    int sent;
    int len;
    int i;
    logic absent;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 3) == 0) len = $urandom_range(1, 20);
      else len = $urandom_range(1, active_keep() + 3);
      for (i = 0; i < len; i++) begin
        absent = ($urandom_range(0, 9) == 0);
        if (i == len - 1 && $urandom_range(0, 3) == 0) absent = 1'b1;
        send_entry(pick_sample(), ROW_BITS'($urandom_range(0, 20'hF_FFFF)), absent,
                   i == len - 1);
      end
      sent += len;
    end
  endtask

  task automatic test_reset_defaults();
    // k = 1, signed ranking out of reset
    send_entry(32'h0, 20'h0, 1'b1, 1'b1);            // empty column: one padding beat
    send_entry(32'h0000_0005, 20'h0, 1'b0, 1'b0);
    send_entry(32'h7FFF_FFFF, 20'hF_FFFF, 1'b0, 1'b1);
    wait_drained();
  endtask

  task automatic test_signed_ranking();
    write_reg(REG_KEEP_COUNT, 5'd4);
    send_entry(32'h8000_0000, 20'hF_FFFF, 1'b0, 1'b0);
    send_entry(32'h0000_0000, 20'h0_0011, 1'b0, 1'b0);
    send_entry(32'hFFFF_FFFF, 20'h0_0022, 1'b0, 1'b0);
    send_entry(32'h0000_0000, 20'h0_0033, 1'b0, 1'b0);  // tie: ranks after the first zero
    send_entry(32'h7FFF_FFFF, 20'h0_0044, 1'b1, 1'b1);  // absent close, value ignored
    wait_drained();
  endtask

  task automatic test_magnitude_ranking();
    write_reg(REG_KEEP_COUNT, 5'd16);
    write_reg(REG_MAGNITUDE_MODE, CFG_DATA_W'(RANK_MAGNITUDE));
    send_entry(32'h7FFF_FFFF, 20'h0_0001, 1'b0, 1'b0);
    send_entry(32'h8000_0000, 20'h0_0002, 1'b0, 1'b0);  // magnitude 2^31 wins
    send_entry(32'hFFFF_FFFD, 20'h0_0003, 1'b0, 1'b0);
    send_entry(32'h0000_0003, 20'h0_0004, 1'b0, 1'b1);
    wait_drained();
  endtask

  task automatic test_tie_eviction();
    write_reg(REG_KEEP_COUNT, 5'd3);
    write_reg(REG_MAGNITUDE_MODE, CFG_DATA_W'(RANK_SIGNED));
    send_entry(32'd10, 20'd100, 1'b0, 1'b0);
    send_entry(32'd10, 20'd101, 1'b0, 1'b0);
    send_entry(32'd10, 20'd102, 1'b0, 1'b0);
    send_entry(32'd10, 20'd103, 1'b0, 1'b0);  // equal to weakest: dropped
    send_entry(32'd11, 20'd104, 1'b0, 1'b1);  // evicts the latest of the tied tens
    wait_drained();
  endtask

  task automatic test_keep_count_clamp();
    write_reg(REG_KEEP_COUNT, 5'd0);          // acts as k = 1
    send_entry(32'd2, 20'd7, 1'b0, 1'b0);
    send_entry(32'd9, 20'd8, 1'b0, 1'b1);
    wait_drained();
    write_reg(REG_KEEP_COUNT, 5'd31);         // saturates to MAX_KEEP
    send_entry(32'hFFFF_0000, 20'd9, 1'b0, 1'b1);
    wait_drained();
  endtask

  task automatic test_keep_lowered_mid_column();
    write_reg(REG_KEEP_COUNT, 5'd6);
    send_entry(32'd4, 20'd40, 1'b0, 1'b0);
    send_entry(32'd1, 20'd41, 1'b0, 1'b0);
    send_entry(32'd3, 20'd42, 1'b0, 1'b0);
    wait_drained();
    write_reg(REG_KEEP_COUNT, 5'd2);          // store now holds more than k
    send_entry(32'd0, 20'd43, 1'b1, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_columns();
    logic [KEEP_W-1:0] keeps[7] = '{5'd16, 5'd1, 5'd31, 5'd2, 5'd8, 5'd0, 5'd12};
    int p;
    for (p = 0; p < 7; p++) begin
      // first phase runs with no gaps or stalls at all
      src_gaps    = (p != 0);
      sink_stalls <= (p != 0);
      write_reg(REG_KEEP_COUNT, keeps[p]);
      write_reg(REG_MAGNITUDE_MODE,
                CFG_DATA_W'(p[0] ? RANK_SIGNED : RANK_MAGNITUDE));
      send_random_columns(PHASE_ITEMS);
      wait_drained();
    end
  endtask

  task automatic test_output_hold_off();
    write_reg(REG_KEEP_COUNT, 5'd5);
    write_reg(REG_MAGNITUDE_MODE, CFG_DATA_W'(RANK_SIGNED));
    // sink holds off while columns keep arriving, so the input must stall
    hold_req <= ~hold_req;
    send_random_columns(PHASE_ITEMS);
    wait_drained();
  endtask

  initial begin : stimulus
    rst                   = 1'b1;
    write_enable          = 1'b0;
    reg_index             = REG_KEEP_COUNT;
    write_data            = '0;
    entry_ch.valid        = 1'b0;
    entry_ch.sample_value = '0;
    entry_ch.row_number   = '0;
    entry_ch.value_absent = 1'b0;
    entry_ch.column_end   = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_signed_ranking();
    test_magnitude_ranking();
    test_tie_eviction();
    test_keep_count_clamp();
    test_keep_lowered_mid_column();
    test_random_columns();
    test_output_hold_off();

    $display("covered %0d columns and %0d ranked beats, k from 0 to 31, both ranking modes",
             columns_closed, beats_checked);
    $display("with source gaps, sink stalls, a long sink hold-off and %0d errors", errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
